/* sv/mjpeg_frame_deframer_macros.svh */
// Assertion macros shared by the frame deframer modules.
`ifndef MJPEG_FRAME_DEFRAMER_MACROS_SVH
`define MJPEG_FRAME_DEFRAMER_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define MFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("deframer check failed");
// Check a property on every clock edge, reset included.
`define MFD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("deframer check failed");
`else
`define MFD_ASSERT(lbl, clk, rst_n, prop)
`define MFD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* sv/mfd_pkg.sv */
// Types and constants shared by the frame deframer modules.
package mfd_pkg;

    localparam int DATA_W    = 8;
    localparam int COUNT_W   = 32;
    localparam int CFG_W     = 24;
    localparam int MIN_LIMIT = 4;
    localparam int DEPTH     = 3;

    localparam logic [DATA_W-1:0] MARK_FF  = 8'hFF;
    localparam logic [DATA_W-1:0] MARK_SOI = 8'hD8;
    localparam logic [DATA_W-1:0] MARK_EOI = 8'hD9;
    localparam logic [CFG_W-1:0]  LIMIT_RESET = 24'h100000;

    typedef logic [1:0] ptr_t;

    // One result item.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               abort;
        logic               last;
        logic               first;
        logic [DATA_W-1:0]  data;
    } result_t;

    // Results produced by one input item: zero, one or two.
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    // Advance a queue pointer modulo the queue depth.
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_inc = (p == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(p + 2'd1);
    endfunction

endpackage

/* sv/mfd_parser.sv */
// Marker search, frame length tracking and result generation for one byte.
`include "mjpeg_frame_deframer_macros.svh"
module mfd_parser
    import mfd_pkg::*;
#(
    parameter int LENGTH_WIDTH = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [DATA_W-1:0]       in_byte,
    input  logic [LENGTH_WIDTH-1:0] limit,
    output push_t                   push
);

    logic                    in_frame_reg, in_frame_next;
    logic                    prev_ff_reg, prev_ff_next;
    logic [LENGTH_WIDTH-1:0] len_reg, len_next;
    logic [COUNT_W-1:0]      count_reg, count_next;

    logic [LENGTH_WIDTH-1:0] len_inc;
    logic                    is_ff;

    assign is_ff   = (in_byte == MARK_FF);
    assign len_inc = (len_reg != '1) ? len_reg + 1'b1 : len_reg;

    // Decode one byte against the current state.
    always_comb begin
        in_frame_next = in_frame_reg;
        prev_ff_next  = prev_ff_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        push          = '0;
        push.r0.count = count_reg;
        push.r1.count = count_reg;
        if (in_valid) begin
            if (!in_frame_reg) begin
                if (prev_ff_reg && in_byte == MARK_SOI) begin
                    // Start marker: emit both marker bytes.
                    in_frame_next  = 1'b1;
                    prev_ff_next   = 1'b0;
                    len_next       = LENGTH_WIDTH'(2);
                    push.n         = 2'd2;
                    push.r0.data   = MARK_FF;
                    push.r0.first  = 1'b1;
                    push.r1.data   = MARK_SOI;
                end else begin
                    prev_ff_next = is_ff;
                end
            end else if (len_inc > limit) begin
                // Frame too long: abort and resume hunting with this byte.
                in_frame_next = 1'b0;
                prev_ff_next  = is_ff;
                len_next      = '0;
                push.n        = 2'd1;
                push.r0.last  = 1'b1;
                push.r0.abort = 1'b1;
            end else if (prev_ff_reg && in_byte == MARK_EOI) begin
                // End marker: close the frame and count it.
                in_frame_next = 1'b0;
                prev_ff_next  = 1'b0;
                len_next      = '0;
                count_next    = count_reg + 1'b1;
                push.n        = 2'd1;
                push.r0.data  = in_byte;
                push.r0.last  = 1'b1;
                push.r0.count = count_reg + 1'b1;
            end else begin
                // Pass the frame byte through.
                prev_ff_next = is_ff;
                len_next     = len_inc;
                push.n       = 2'd1;
                push.r0.data = in_byte;
            end
        end
    end

    // Hold parser state.
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            in_frame_reg <= 1'b0;
            prev_ff_reg  <= 1'b0;
            len_reg      <= '0;
            count_reg    <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            prev_ff_reg  <= prev_ff_next;
            len_reg      <= len_next;
            count_reg    <= count_next;
        end
    end

    `MFD_ASSERT(a_hunt_len_zero, clk, rst_n, !in_frame_reg |-> len_reg == '0)
    `MFD_ASSERT(a_frame_one_result, clk, rst_n, (in_valid && in_frame_reg) |-> push.n == 2'd1)
    `MFD_ASSERT(a_pair_opens, clk, rst_n, (in_valid && push.n == 2'd2) |=> in_frame_reg)

endmodule

/* sv/mfd_out_queue.sv */
// Three-entry result queue that takes up to two results per cycle.
`include "mjpeg_frame_deframer_macros.svh"
module mfd_out_queue
    import mfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    result_t mem_reg [DEPTH];
    ptr_t    wr_reg, wr_next;
    ptr_t    rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic    pop;
    ptr_t    wr_plus1;

    assign wr_plus1  = ptr_inc(wr_reg);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    // Accept a new item only when two free entries are guaranteed.
    assign room      = (cnt_reg <= 2'd1);

    // Advance pointers and fill level.
    always_comb begin
        rd_next  = pop ? ptr_inc(rd_reg) : rd_reg;
        wr_next  = wr_reg;
        if (push.n == 2'd1) begin
            wr_next = wr_plus1;
        end else if (push.n == 2'd2) begin
            wr_next = ptr_inc(wr_plus1);
        end
        cnt_next = cnt_reg - {1'b0, pop} + push.n;
    end

    // Write incoming results.
    always_ff @(posedge clk) begin
        if (push.n != 2'd0) begin
            mem_reg[wr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_plus1] <= push.r1;
        end
    end

    // Hold queue control state.
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    `MFD_ASSERT(a_no_overflow, clk, rst_n, ({1'b0, cnt_reg} + {1'b0, push.n}) <= 3'd3 + {2'b0, pop})
    `MFD_ASSERT(a_pop_drains, clk, rst_n, (pop && push.n == 2'd0) |=> cnt_reg == $past(cnt_reg) - 2'd1)
    `MFD_ASSERT(a_rd_in_range, clk, rst_n, rd_reg != 2'd3)

endmodule

/* sv/mjpeg_frame_deframer.sv */
// Top level: cuts JPEG frames between FF D8 and FF D9 out of a byte stream.
// A result is written into the output queue when its byte is accepted and leaves it on the m_ side.
// Throughput: one byte per cycle while s_tready is high; a start marker emits two results, and
// s_tready stays low while the three-entry output queue holds two results or more.
// Reset (aresetn low, synchronous): hunting state, counters zero, queue empty,
// byte limit back to 1048576.
module mjpeg_frame_deframer
    import mfd_pkg::*;
#(
    parameter int LENGTH_WIDTH = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,     // [7:0] in_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,     // [7:0] out_byte, [39:8] frames_received
    output logic [1:0]        m_tuser,     // [0] frame_first, [1] frame_abort
    output logic              m_tlast,     // frame_last
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata    // max_frame_bytes
);

    localparam int CW = (LENGTH_WIDTH > CFG_W) ? LENGTH_WIDTH : CFG_W;

    logic [CFG_W-1:0]        limit_reg;
    logic [CW-1:0]           cfg_ext;
    logic [CW-1:0]           len_max_ext;
    logic [CW-1:0]           lim_ext;
    logic [LENGTH_WIDTH-1:0] limit;
    logic                    in_acc;
    push_t                   push;
    result_t                 out_item;

    // Hold the byte limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // Clamp the limit to at least four bytes and at most the length range.
    assign cfg_ext     = CW'(limit_reg);
    assign len_max_ext = CW'({LENGTH_WIDTH{1'b1}});
    assign lim_ext     = (cfg_ext < CW'(MIN_LIMIT)) ? CW'(MIN_LIMIT) :
                         (cfg_ext > len_max_ext) ? len_max_ext : cfg_ext;
    assign limit       = lim_ext[LENGTH_WIDTH-1:0];

    assign in_acc = s_tvalid && s_tready;

    mfd_parser #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_parser (
        .clk      (aclk),
        .rst_n    (aresetn),
        .in_valid (in_acc),
        .in_byte  (s_tdata),
        .limit    (limit),
        .push     (push)
    );

    mfd_out_queue u_queue (
        .clk       (aclk),
        .rst_n     (aresetn),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // Pack the result item onto the stream.
    assign m_tdata = {out_item.count, out_item.data};
    assign m_tuser = {out_item.abort, out_item.first};
    assign m_tlast = out_item.last;

endmodule

/* verif/mjpeg_frame_deframer_tb.sv */
// Self-checking testbench for the JPEG frame deframer: directed and random byte streams.
module mjpeg_frame_deframer_tb
    import mfd_pkg::*;
();

    localparam int          LEN_W       = 24;
    localparam logic [31:0] LEN_MAX     = (32'd1 << LEN_W) - 32'd1;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SETTLE      = 4;
    localparam int          DRAIN       = 10;
    localparam int          HOLD_CYCLES = 300;
    localparam int          ITEM_GOAL   = 1900;

    // Scoreboard: predicts the deframer and checks its result items in order.
    class frame_scoreboard;
        logic [CFG_W-1:0]   limit;
        bit                 in_frame;
        bit                 prev_ff;
        logic [LEN_W-1:0]   length;
        logic [COUNT_W-1:0] frames;
        result_t            expected_q[$];
        int                 errors;
        int                 checked;
        int                 completed;
        int                 aborted;

        function new();
            limit     = LIMIT_RESET;
            in_frame  = 1'b0;
            prev_ff   = 1'b0;
            length    = '0;
            frames    = '0;
            errors    = 0;
            checked   = 0;
            completed = 0;
            aborted   = 0;
        endfunction

        function void set_limit(logic [CFG_W-1:0] v);
            limit = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_expected(logic [7:0] data, bit first, bit last, bit abrt);
            result_t r;
            r.data  = data;
            r.first = first;
            r.last  = last;
            r.abort = abrt;
            r.count = frames;
            expected_q.push_back(r);
        endfunction

        // Advance the predicted state by one accepted byte; return how many results it causes.
        function int note_byte(logic [7:0] b);
            logic [31:0] lim;
            lim = 32'(limit);
            if (lim < MIN_LIMIT)
                lim = MIN_LIMIT;
            if (lim > LEN_MAX)
                lim = LEN_MAX;

            // Hunting: drop bytes until FF D8
            if (!in_frame) begin
                if (prev_ff && b == MARK_SOI) begin
                    in_frame = 1'b1;
                    prev_ff  = 1'b0;
                    length   = LEN_W'(2);
                    add_expected(MARK_FF, 1'b1, 1'b0, 1'b0);
                    add_expected(MARK_SOI, 1'b0, 1'b0, 1'b0);
                    return 2;
                end
                prev_ff = (b == MARK_FF);
                return 0;
            end

            // Saturating length, then the limit check
            if (32'(length) != LEN_MAX)
                length = length + LEN_W'(1);
            if (32'(length) > lim) begin
                in_frame = 1'b0;
                length   = '0;
                prev_ff  = (b == MARK_FF);
                aborted++;
                add_expected(8'h00, 1'b0, 1'b1, 1'b1);
                return 1;
            end

            // End marker closes the frame
            if (prev_ff && b == MARK_EOI) begin
                in_frame = 1'b0;
                prev_ff  = 1'b0;
                length   = '0;
                frames   = frames + 1'b1;
                completed++;
                add_expected(b, 1'b0, 1'b1, 1'b0);
                return 1;
            end

            prev_ff = (b == MARK_FF);
            add_expected(b, 1'b0, 1'b0, 1'b0);
            return 1;
        endfunction

        task report(string msg);
            if (errors < 50)
                $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Compare one accepted result with the oldest expected one.
        task check_result(result_t got);
            result_t exp;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result data %h first %b last %b abort %b count %0d",
                                 got.data, got.first, got.last, got.abort, got.count));
                return;
            end
            exp = expected_q.pop_front();
            if (got.data !== exp.data || got.first !== exp.first || got.last !== exp.last ||
                got.abort !== exp.abort || got.count !== exp.count)
                report($sformatf("result %0d: got %h/%b/%b/%b/%0d, expected %h/%b/%b/%b/%0d",
                                 checked, got.data, got.first, got.last, got.abort, got.count,
                                 exp.data, exp.first, exp.last, exp.abort, exp.count));
            checked++;
        endtask
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = 8'h00;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [39:0]        m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;
    logic               cfg_we    = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;

    frame_scoreboard    sb;
    int                 src_idle_pct  = 20;
    int                 sink_idle_pct = 60;
    bit                 hold_req      = 1'b0;
    int                 cycles        = 0;
    int                 accepted      = 0;
    int                 busy_items    = 0;
    int                 cfg_writes    = 0;

    mjpeg_frame_deframer #(
        .LENGTH_WIDTH(LEN_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Clock: period 10
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on total run length
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: check accepted results, then pick m_tready for the next edge
    always @(posedge aclk) begin : sink
        result_t got;
        bit      hold_done;
        int      hold_left;
        if (aresetn && m_tvalid && m_tready) begin
            got.data  = m_tdata[7:0];
            got.count = m_tdata[39:8];
            got.first = m_tuser[0];
            got.abort = m_tuser[1];
            got.last  = m_tlast;
            sb.check_result(got);
        end
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offer one byte, idling first at random, and hold it until accepted.
    task automatic send_byte(input logic [7:0] b);
        int n;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        n = sb.note_byte(b);
        accepted++;
        if (n != 0)
            busy_items++;
    endtask

    task automatic send_seq(input logic [7:0] seq[$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Drop valid and wait until every expected result has come out.
    task automatic wait_drained(input int settle);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // Write the byte limit while the block is idle.
    task automatic write_limit(input logic [CFG_W-1:0] v);
        wait_drained(SETTLE);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_limit(v);
        cfg_writes++;
    endtask

    // One random run: noise, sometimes a broken start, start marker, body, usually an end marker.
    task automatic send_random_run();
        int         body;
        int         pick;
        logic [7:0] b;
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
        // Occasionally a broken start: FF not followed by D8
        if ($urandom_range(0, 7) == 0) begin
            send_byte(MARK_FF);
            send_byte(8'($urandom_range(0, 255)));
        end
        send_byte(MARK_FF);
        send_byte(MARK_SOI);
        body = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 16);
        repeat (body) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       b = MARK_FF;
                1:       b = MARK_EOI;
                2:       b = MARK_SOI;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b);
        end
        if ($urandom_range(0, 9) != 0) begin
            send_byte(MARK_FF);
            send_byte(MARK_EOI);
        end
    endtask

    // Limit for random segment k: extremes, clamped values, the reset value, full random and small random limits.
    function automatic logic [CFG_W-1:0] segment_limit(input int k);
        case (k % 12)
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom_range(4, 40));
            3:       return CFG_W'(3);
            4:       return LIMIT_RESET;
            5:       return CFG_W'($urandom_range(5, 20));
            6:       return CFG_W'(1);
            7:       return CFG_W'($urandom_range(4, 12));
            8:       return CFG_W'(2);
            9:       return CFG_W'($urandom);
            10:      return CFG_W'(4);
            default: return CFG_W'($urandom_range(6, 30));
        endcase
    endfunction

    initial begin : main
        logic [7:0] seq[$];
        int         goal;
        sb = new();

        // Hold reset at the start, then release it
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: repeated FF, marker overlap, stray markers, extremes 00 and FF
        seq = '{8'h00, 8'hFF, 8'hFF, 8'hD8, 8'hD9, 8'hFF, 8'hD9, 8'hD8,
                8'hFF, 8'hD8, 8'hFF, 8'hFF, 8'hD9};
        send_seq(seq);

        // Limit below the minimum acts as 4
        write_limit('0);
        seq = '{8'hFF, 8'hD8, 8'hAA, 8'hBB, 8'hCC};
        send_seq(seq);

        // Overflowing FF aborts and then starts the next marker
        write_limit(CFG_W'(5));
        seq = '{8'hFF, 8'hD8, 8'h01, 8'h02, 8'h03, 8'hFF, 8'hD8, 8'hFF, 8'hD9};
        send_seq(seq);

        // Random: three idle regimes, four limit settings each
        for (int phase = 0; phase < 3; phase++) begin
            wait_drained(SETTLE);
            case (phase)
                0: begin
                    src_idle_pct  = 20;
                    sink_idle_pct = 60;
                end
                1: begin
                    src_idle_pct  = 60;
                    sink_idle_pct = 20;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            if (phase == 2) begin
                // Long hold-off on the receiver while a long frame keeps coming
                write_limit('1);
                hold_req = 1'b1;
                send_byte(MARK_FF);
                send_byte(MARK_SOI);
                repeat (80) send_byte(8'($urandom_range(0, 254)));
                send_byte(MARK_FF);
                send_byte(MARK_EOI);
            end
            for (int seg = 0; seg < 4; seg++) begin
                write_limit(segment_limit(phase * 4 + seg));
                goal = accepted + ITEM_GOAL / 12;
                while (accepted < goal)
                    send_random_run();
            end
        end

        // Drain and finish
        wait_drained(DRAIN);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        $display("Covered %0d bytes offered in (%0d inside frames), %0d results checked, %0d limit writes",
                 accepted, busy_items, sb.checked, cfg_writes);
        $display("Frames completed %0d, frames aborted %0d, mismatches %0d",
                 sb.completed, sb.aborted, sb.errors);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
